// ----- rtl/ultrasonic_ranging_with_smoothing_core_assert.svh -----
// Assertion macros used by the ultrasonic ranging RTL.
// Expects signals named clk and rst_n in the including module; no other dependencies.
`ifndef ULTRASONIC_RANGING_WITH_SMOOTHING_CORE_ASSERT_SVH
`define ULTRASONIC_RANGING_WITH_SMOOTHING_CORE_ASSERT_SVH

// Check a condition in the same cycle as its antecedent
`define URS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a condition in the cycle after its antecedent
`define URS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/urs_pkg.sv -----
// Types and constants for the ultrasonic ranging core with smoothing.
// No dependencies; used by ultrasonic_ranging_with_smoothing_core.
package urs_pkg;

  // Counter width default and fixed register widths
  localparam int TIMER_BITS_DEF = 19;
  localparam int TRIG_WIDTH_W   = 8;
  localparam int TIMEOUT_W      = 19;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 19;

  // Register reset values
  localparam logic [TRIG_WIDTH_W-1:0] TRIG_WIDTH_RST = 8'd10;
  localparam logic [TIMEOUT_W-1:0]    TIMEOUT_RST    = 19'd100000;

  // Width to mm: (width * 11151) >> 16, approx 340.29 m/s / 2000
  localparam int              MM_SCALE_W = 14;
  localparam logic [13:0]     MM_SCALE   = 14'd11151;
  localparam int              MM_SHIFT   = 16;
  localparam int              MM_W       = 16;
  localparam int              SMOOTH_SH  = 5;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TRIG_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ECHO_TIMEOUT = 2'd1;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_TRIG = 2'd1,
    PH_WAIT = 2'd2
  } phase_t;

  typedef struct packed {
    logic start_req;
    logic first;
    logic echo_level;
  } urs_in_t;

  typedef struct packed {
    logic            trigger_level;
    logic            busy_res;
    logic            done_res;
    logic            no_response;
    logic [MM_W-1:0] raw_mm;
    logic [MM_W-1:0] smoothed_mm;
  } urs_out_t;

endpackage

// ----- rtl/ultrasonic_ranging_with_smoothing_core.sv -----
// Ultrasonic ranging core: one input word per microsecond tick, one result word per input
// word. Each word is handled completely in the cycle it is accepted; its result word is
// registered into the output register, or into the skid entry while the output is stalled.
// One word can be accepted every cycle while in_ready is high; the longest path is the
// width-to-mm multiply and smoothing add. The skid entry holds one result word that met a
// stalled output; while it is full, in_ready is low until the word has moved on.
// Depends on urs_pkg and ultrasonic_ranging_with_smoothing_core_assert.svh.
`include "ultrasonic_ranging_with_smoothing_core_assert.svh"

module ultrasonic_ranging_with_smoothing_core #(
  parameter int TIMER_BITS = urs_pkg::TIMER_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  urs_pkg::urs_in_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output urs_pkg::urs_out_t                out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [urs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [urs_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CW = (TIMER_BITS > urs_pkg::TIMEOUT_W) ? TIMER_BITS : urs_pkg::TIMEOUT_W;
  localparam int PW = TIMER_BITS + urs_pkg::MM_SCALE_W;
  localparam int SW = urs_pkg::MM_W + urs_pkg::SMOOTH_SH;
  localparam logic [TIMER_BITS-1:0] CNT_MAX = {TIMER_BITS{1'b1}};

  function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  // Configuration registers
  logic [urs_pkg::TRIG_WIDTH_W-1:0] trig_width_r;
  logic [urs_pkg::TIMEOUT_W-1:0]    timeout_r;

  // Measurement state
  urs_pkg::phase_t          phase_r, phase_nxt;
  logic [TIMER_BITS-1:0]    phase_cnt_r, phase_cnt_nxt;
  logic [TIMER_BITS-1:0]    width_cnt_r, width_cnt_nxt;
  logic                     rising_seen_r, rising_seen_nxt;
  logic                     prev_echo_r;
  logic                     want_first_r, want_first_nxt;
  logic [urs_pkg::MM_W-1:0] last_raw_r, last_raw_nxt;
  logic [urs_pkg::MM_W-1:0] smoothed_r, smoothed_nxt;

  // Output register and skid entry
  logic              out_valid_r, out_valid_nxt;
  urs_pkg::urs_out_t out_data_r, out_data_nxt;
  logic              skid_valid_r, skid_valid_nxt;
  urs_pkg::urs_out_t skid_data_r, skid_data_nxt;

  logic              in_fire;
  logic              rise, fall;
  logic              trig, done, no_resp;
  logic [PW-1:0]     prod, prod_q;
  logic [urs_pkg::MM_W-1:0] mm;
  logic [SW-1:0]     smooth_sum;
  urs_pkg::urs_out_t res;

  assign in_ready  = !skid_valid_r;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Hold configuration; writes to unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_width_r <= urs_pkg::TRIG_WIDTH_RST;
      timeout_r    <= urs_pkg::TIMEOUT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        urs_pkg::CFG_TRIG_WIDTH:   trig_width_r <= cfg_data[urs_pkg::TRIG_WIDTH_W-1:0];
        urs_pkg::CFG_ECHO_TIMEOUT: timeout_r    <= cfg_data[urs_pkg::TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance one tick of the measurement sequencer
  always_comb begin
    rise            = in_data.echo_level && !prev_echo_r;
    fall            = !in_data.echo_level && prev_echo_r;
    phase_nxt       = phase_r;
    phase_cnt_nxt   = phase_cnt_r;
    width_cnt_nxt   = width_cnt_r;
    rising_seen_nxt = rising_seen_r;
    want_first_nxt  = want_first_r;
    last_raw_nxt    = last_raw_r;
    smoothed_nxt    = smoothed_r;
    trig            = 1'b0;
    done            = 1'b0;
    no_resp         = 1'b0;
    prod            = '0;
    prod_q          = '0;
    mm              = '0;
    smooth_sum      = '0;

    unique case (phase_r)
      urs_pkg::PH_TRIG, urs_pkg::PH_WAIT: ;
      default: begin
        phase_nxt = urs_pkg::PH_IDLE;
        if (in_data.start_req) begin
          phase_nxt       = urs_pkg::PH_TRIG;
          phase_cnt_nxt   = '0;
          width_cnt_nxt   = '0;
          rising_seen_nxt = 1'b0;
          want_first_nxt  = in_data.first;
        end
      end
    endcase

    if (phase_nxt != urs_pkg::PH_IDLE) begin
      // Track echo width
      if (rise) begin
        rising_seen_nxt = 1'b1;
        width_cnt_nxt   = '0;
      end else if (rising_seen_nxt) begin
        width_cnt_nxt = sat_inc(width_cnt_nxt);
      end

      // Convert echo width to mm and form the smoothed value
      prod       = PW'(width_cnt_nxt) * PW'(urs_pkg::MM_SCALE);
      prod_q     = prod >> urs_pkg::MM_SHIFT;
      mm         = (prod_q > PW'({urs_pkg::MM_W{1'b1}})) ? {urs_pkg::MM_W{1'b1}}
                                                          : prod_q[urs_pkg::MM_W-1:0];
      smooth_sum = ({smoothed_r, {urs_pkg::SMOOTH_SH{1'b0}}} - SW'(smoothed_r)) + SW'(mm);

      if (fall) begin
        done          = 1'b1;
        phase_nxt     = urs_pkg::PH_IDLE;
        phase_cnt_nxt = '0;
        if (!rising_seen_nxt) begin
          no_resp      = 1'b1;
          last_raw_nxt = '0;
        end else begin
          last_raw_nxt = mm;
          smoothed_nxt = want_first_nxt ? mm
                                        : smooth_sum[SW-1:urs_pkg::SMOOTH_SH];
        end
      end else if (phase_nxt == urs_pkg::PH_TRIG) begin
        trig          = 1'b1;
        phase_cnt_nxt = sat_inc(phase_cnt_nxt);
        if (phase_cnt_nxt >= TIMER_BITS'(trig_width_r)) begin
          phase_nxt     = urs_pkg::PH_WAIT;
          phase_cnt_nxt = '0;
        end
      end else begin
        phase_cnt_nxt = sat_inc(phase_cnt_nxt);
        if ((CW'(phase_cnt_nxt) >= CW'(timeout_r)) || (phase_cnt_nxt == CNT_MAX)) begin
          done          = 1'b1;
          no_resp       = 1'b1;
          phase_nxt     = urs_pkg::PH_IDLE;
          phase_cnt_nxt = '0;
          last_raw_nxt  = '0;
        end
      end
    end

    res.trigger_level = trig;
    res.busy_res      = (phase_nxt != urs_pkg::PH_IDLE);
    res.done_res      = done;
    res.no_response   = no_resp;
    res.raw_mm        = last_raw_nxt;
    res.smoothed_mm   = smoothed_nxt;
  end

  // Update measurement state on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= urs_pkg::PH_IDLE;
      phase_cnt_r   <= '0;
      width_cnt_r   <= '0;
      rising_seen_r <= 1'b0;
      prev_echo_r   <= 1'b0;
      want_first_r  <= 1'b0;
      last_raw_r    <= '0;
      smoothed_r    <= '0;
    end else if (in_fire) begin
      phase_r       <= phase_nxt;
      phase_cnt_r   <= phase_cnt_nxt;
      width_cnt_r   <= width_cnt_nxt;
      rising_seen_r <= rising_seen_nxt;
      prev_echo_r   <= in_data.echo_level;
      want_first_r  <= want_first_nxt;
      last_raw_r    <= last_raw_nxt;
      smoothed_r    <= smoothed_nxt;
    end
  end

  // Steer results into the output register or the skid entry
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (out_valid_r && out_ready) begin
      if (skid_valid_r) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
    if (in_fire) begin
      if (!out_valid_r || out_ready) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = res;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  `URS_ASSERT_SAME(a_skid_behind_out, skid_valid_r, out_valid_r, "skid word without output word")
  `URS_ASSERT_SAME(a_trig_busy, out_valid_r && out_data_r.trigger_level, out_data_r.busy_res,
    "trigger driven while not busy")
  `URS_ASSERT_SAME(a_fail_raw_zero, out_valid_r && out_data_r.no_response,
    out_data_r.done_res && (out_data_r.raw_mm == '0), "failure without done or with distance")
  `URS_ASSERT_NEXT(a_idle_holds, in_fire && (phase_r == urs_pkg::PH_IDLE) && !in_data.start_req,
    phase_r == urs_pkg::PH_IDLE, "left idle without a start request")

endmodule

// ----- verif/tb_ultrasonic_ranging_with_smoothing_core.sv -----
`timescale 1ns / 1ps
// Testbench for ultrasonic_ranging_with_smoothing_core. It sends directed and random tick
// streams and checks every result word against a tick-level predictor of ranging and smoothing.
// Depends on urs_pkg and the core RTL.
module tb_ultrasonic_ranging_with_smoothing_core;

  localparam int TICK_BITS = urs_pkg::TIMER_BITS_DEF;
  localparam logic [TICK_BITS-1:0] TICK_SAT = '1;
  localparam int KEEP_WEIGHT = (1 << urs_pkg::SMOOTH_SH) - 1;
  localparam logic [urs_pkg::CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [urs_pkg::CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
  localparam int MAX_TIMEOUT = 300000;
  localparam int MAX_TRIG = 255;
  localparam int LONG_ECHO_TICKS = 150;
  localparam int RANDOM_TICKS = 250;
  localparam int SEGMENT_TICKS = 200;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int PRINT_CAP = 40;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  urs_pkg::urs_in_t     in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  urs_pkg::urs_out_t    out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [urs_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [urs_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  urs_pkg::urs_out_t pending_results[$];
  int       error_count = 0;
  int       result_count = 0;
  int       ticks_sent = 0;
  int       cycle_count = 0;
  bit       steady = 1'b0;

  // Predicted measurement state and register copies
  urs_pkg::phase_t                  pr_phase = urs_pkg::PH_IDLE;
  logic [TICK_BITS-1:0]             pr_phase_cnt = '0;
  logic [TICK_BITS-1:0]             pr_width_cnt = '0;
  logic                             pr_rise_seen = 1'b0;
  logic                             pr_prev_echo = 1'b0;
  logic                             pr_want_first = 1'b0;
  logic [urs_pkg::MM_W-1:0]         pr_last_mm = '0;
  logic [urs_pkg::MM_W-1:0]         pr_smooth_mm = '0;
  logic [urs_pkg::TRIG_WIDTH_W-1:0] pr_trig_width = urs_pkg::TRIG_WIDTH_RST;
  logic [urs_pkg::TIMEOUT_W-1:0]    pr_echo_timeout = urs_pkg::TIMEOUT_RST;

  ultrasonic_ranging_with_smoothing_core #(
    .TIMER_BITS(TICK_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Saturating tick counter
  function automatic logic [TICK_BITS-1:0] tick_up(input logic [TICK_BITS-1:0] v);
    return (v == TICK_SAT) ? v : v + 1'b1;
  endfunction

  // Echo width in ticks to millimeters, clipped to 16 bits
  function automatic logic [urs_pkg::MM_W-1:0] width_to_distance(input logic [TICK_BITS-1:0] w);
    logic [63:0] scaled;
    scaled = (64'(w) * 64'(urs_pkg::MM_SCALE)) >> urs_pkg::MM_SHIFT;
    return (scaled > 64'hFFFF) ? 16'hFFFF : scaled[urs_pkg::MM_W-1:0];
  endfunction

  // Close the measurement and update the distances; return the no-response flag
  function automatic logic close_measurement(input logic echo_ok);
    logic [31:0] blend;
    pr_phase = urs_pkg::PH_IDLE;
    pr_phase_cnt = '0;
    if (!echo_ok) begin
      pr_last_mm = '0;
      return 1'b1;
    end
    pr_last_mm = width_to_distance(pr_width_cnt);
    blend = (KEEP_WEIGHT * 32'(pr_smooth_mm) + 32'(pr_last_mm)) >> urs_pkg::SMOOTH_SH;
    pr_smooth_mm = pr_want_first ? pr_last_mm : blend[urs_pkg::MM_W-1:0];
    return 1'b0;
  endfunction

  // Advance the predicted state by one tick and return the expected result word
  function automatic urs_pkg::urs_out_t ranging_tick(input urs_pkg::urs_in_t w);
    urs_pkg::urs_out_t r;
    logic     rise;
    logic     fall;
    rise = w.echo_level && !pr_prev_echo;
    fall = !w.echo_level && pr_prev_echo;
    pr_prev_echo = w.echo_level;
    r = '0;
    if (pr_phase != urs_pkg::PH_TRIG && pr_phase != urs_pkg::PH_WAIT) begin
      pr_phase = urs_pkg::PH_IDLE;
      if (w.start_req) begin
        pr_phase = urs_pkg::PH_TRIG;
        pr_phase_cnt = '0;
        pr_width_cnt = '0;
        pr_rise_seen = 1'b0;
        pr_want_first = w.first;
      end
    end
    if (pr_phase != urs_pkg::PH_IDLE) begin
      // Capture echo edges from the first trigger tick on
      if (rise) begin
        pr_rise_seen = 1'b1;
        pr_width_cnt = '0;
      end else if (pr_rise_seen) begin
        pr_width_cnt = tick_up(pr_width_cnt);
      end
      if (fall) begin
        r.done_res = 1'b1;
        r.no_response = close_measurement(pr_rise_seen);
      end else if (pr_phase == urs_pkg::PH_TRIG) begin
        r.trigger_level = 1'b1;
        pr_phase_cnt = tick_up(pr_phase_cnt);
        if (32'(pr_phase_cnt) >= 32'(pr_trig_width)) begin
          pr_phase = urs_pkg::PH_WAIT;
          pr_phase_cnt = '0;
        end
      end else begin
        pr_phase_cnt = tick_up(pr_phase_cnt);
        if (32'(pr_phase_cnt) >= 32'(pr_echo_timeout) || pr_phase_cnt == TICK_SAT) begin
          r.done_res = 1'b1;
          r.no_response = close_measurement(1'b0);
        end
      end
    end
    r.busy_res = (pr_phase != urs_pkg::PH_IDLE);
    r.raw_mm = pr_last_mm;
    r.smoothed_mm = pr_smooth_mm;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    if (error_count <= PRINT_CAP)
      $display("%0t ns word %0d: %s got %0d expected %0d", $time, result_count, what, got, want);
  endtask

  // Mostly no gap, some short ones, a few long ones
  function automatic int idle_span();
    int pick;
    pick = $urandom_range(0, 99);
    if (steady || pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Compare each delivered result word with the oldest prediction
  always @(posedge clk) begin : check_results
    urs_pkg::urs_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.trigger_level !== want.trigger_level)
          report_mismatch("trigger_level", int'(out_data.trigger_level),
                          int'(want.trigger_level));
        if (out_data.busy_res !== want.busy_res)
          report_mismatch("busy_res", int'(out_data.busy_res), int'(want.busy_res));
        if (out_data.done_res !== want.done_res)
          report_mismatch("done_res", int'(out_data.done_res), int'(want.done_res));
        if (out_data.no_response !== want.no_response)
          report_mismatch("no_response", int'(out_data.no_response), int'(want.no_response));
        if (out_data.raw_mm !== want.raw_mm)
          report_mismatch("raw_mm", int'(out_data.raw_mm), int'(want.raw_mm));
        if (out_data.smoothed_mm !== want.smoothed_mm)
          report_mismatch("smoothed_mm", int'(out_data.smoothed_mm), int'(want.smoothed_mm));
      end
      result_count++;
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Stall the result side in bursts, with long stretches of steady ready
  initial begin : drive_out_ready
    int hold_left;
    int stall_left;
    hold_left = 0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (steady) begin
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b1;
      end else begin
        hold_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(0, 12);
        stall_left = idle_span();
        out_ready <= (stall_left == 0);
      end
    end
  end

  // Send one tick word and record its expected result once accepted
  task automatic push_tick(input logic start, input logic first_flag, input logic echo);
    urs_pkg::urs_in_t word;
    int      gap;
    word.start_req = start;
    word.first = first_flag;
    word.echo_level = echo;
    gap = idle_span();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= word;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(ranging_tick(word));
    ticks_sent++;
  endtask

  // Feed low echo until no measurement runs and the echo line is low
  task automatic settle_measurement();
    while (pr_phase != urs_pkg::PH_IDLE || pr_prev_echo)
      push_tick(1'b0, 1'($urandom_range(0, 1)), 1'b0);
  endtask

  // Write a register once the core is idle and every result has come back
  task automatic write_reg(input logic [urs_pkg::CFG_IDX_W-1:0] idx, input int value);
    settle_measurement();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[urs_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      urs_pkg::CFG_TRIG_WIDTH:   pr_trig_width = value[urs_pkg::TRIG_WIDTH_W-1:0];
      urs_pkg::CFG_ECHO_TIMEOUT: pr_echo_timeout = value[urs_pkg::TIMEOUT_W-1:0];
      default: ;
    endcase
  endtask

  // Start a measurement, hold echo low then high, then let it finish
  task automatic fire_and_echo(input logic first_flag, input int low_ticks, input int high_ticks,
                               input bit noisy);
    for (int t = 0; t < low_ticks + high_ticks; t++) begin
      if (t == 0)
        push_tick(1'b1, first_flag, low_ticks == 0);
      else if (noisy)
        push_tick($urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)), t >= low_ticks);
      else
        push_tick(1'b0, 1'($urandom_range(0, 1)), t >= low_ticks);
    end
    settle_measurement();
  endtask

  task automatic test_default_registers();
    push_tick(1'b0, 1'b1, 1'b0);
    push_tick(1'b0, 1'b0, 1'b0);
    fire_and_echo(1'b1, 12, 40, 1'b0);
    fire_and_echo(1'b0, 15, 120, 1'b0);
  endtask

  task automatic test_trigger_extremes();
    // Zero width behaves as one tick
    write_reg(urs_pkg::CFG_TRIG_WIDTH, 0);
    fire_and_echo(1'b1, 3, 20, 1'b0);
    write_reg(urs_pkg::CFG_TRIG_WIDTH, 1);
    fire_and_echo(1'b0, 2, 25, 1'b0);
    write_reg(urs_pkg::CFG_TRIG_WIDTH, MAX_TRIG);
    fire_and_echo(1'b0, MAX_TRIG + 4, 60, 1'b0);
  endtask

  task automatic test_timeouts();
    write_reg(urs_pkg::CFG_TRIG_WIDTH, 2);
    // Zero timeout behaves as one tick; no echo at all
    write_reg(urs_pkg::CFG_ECHO_TIMEOUT, 0);
    fire_and_echo(1'b1, 8, 0, 1'b0);
    write_reg(urs_pkg::CFG_ECHO_TIMEOUT, 1);
    fire_and_echo(1'b0, 6, 0, 1'b0);
    // Echo rises but outlasts the wait; smoothed value must hold
    write_reg(urs_pkg::CFG_ECHO_TIMEOUT, 6);
    fire_and_echo(1'b0, 3, 30, 1'b0);
    fire_and_echo(1'b0, 3, 3, 1'b0);
  endtask

  task automatic test_early_edges();
    write_reg(urs_pkg::CFG_TRIG_WIDTH, 20);
    write_reg(urs_pkg::CFG_ECHO_TIMEOUT, 40);
    // Whole echo inside the trigger pulse
    fire_and_echo(1'b1, 3, 4, 1'b0);
    // Echo already high at start, so the first edge is a fall
    push_tick(1'b0, 1'b0, 1'b1);
    push_tick(1'b0, 1'b1, 1'b1);
    push_tick(1'b1, 1'b1, 1'b0);
    settle_measurement();
    push_tick(1'b0, 1'b0, 1'b1);
    push_tick(1'b1, 1'b0, 1'b1);
    repeat (24) push_tick(1'b0, 1'b0, 1'b1);
    settle_measurement();
    // Rise on the first trigger tick
    fire_and_echo(1'b0, 0, 8, 1'b0);
  endtask

  task automatic test_start_while_busy();
    write_reg(urs_pkg::CFG_TRIG_WIDTH, 4);
    write_reg(urs_pkg::CFG_ECHO_TIMEOUT, 30);
    push_tick(1'b1, 1'b0, 1'b0);
    repeat (7) push_tick(1'b1, 1'b1, 1'b0);
    for (int t = 0; t < 10; t++) push_tick(1'b1, t[0], 1'b1);
    settle_measurement();
  endtask

  task automatic test_register_decode();
    // Spare indexes change nothing; upper data bits of the width are dropped
    write_reg(CFG_SPARE_2, 'h7FFFF);
    write_reg(CFG_SPARE_3, $urandom_range(0, 'h7FFFF));
    write_reg(urs_pkg::CFG_TRIG_WIDTH, 'h5A03);
    write_reg(urs_pkg::CFG_ECHO_TIMEOUT, 20);
    fire_and_echo(1'b1, 5, 10, 1'b0);
  endtask

  task automatic test_long_echo();
    // Long wait; the echo ends well inside it
    steady = 1'b1;
    write_reg(urs_pkg::CFG_TRIG_WIDTH, 10);
    write_reg(urs_pkg::CFG_ECHO_TIMEOUT, MAX_TIMEOUT);
    fire_and_echo(1'b0, 12, LONG_ECHO_TICKS, 1'b0);
    steady = 1'b0;
  endtask

  task automatic test_random_traffic();
    int stop_at;
    int seg_end;
    int trig;
    int tmo;
    int pick;
    int burst;
    stop_at = ticks_sent + RANDOM_TICKS;
    while (ticks_sent < stop_at) begin
      pick = $urandom_range(0, 9);
      trig = (pick == 0) ? 0 : (pick == 1) ? MAX_TRIG : $urandom_range(1, 12);
      pick = $urandom_range(0, 9);
      tmo = (pick == 0) ? $urandom_range(0, 1) : $urandom_range(2, 60);
      write_reg(urs_pkg::CFG_TRIG_WIDTH, trig);
      write_reg(urs_pkg::CFG_ECHO_TIMEOUT, tmo);
      steady = ($urandom_range(0, 4) == 0);
      seg_end = ticks_sent + SEGMENT_TICKS;
      while (ticks_sent < seg_end && ticks_sent < stop_at) begin
        // Mostly well-formed pulses, some raw noise
        if ($urandom_range(0, 3) != 0) begin
          fire_and_echo(1'($urandom_range(0, 1)), $urandom_range(0, trig + tmo + 3),
                        $urandom_range(1, tmo + 5), $urandom_range(0, 3) == 0);
        end else begin
          burst = $urandom_range(1, 16);
          repeat (burst)
            push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
          settle_measurement();
        end
      end
    end
    steady = 1'b0;
  endtask

  initial begin : run_tests
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_registers();
    test_trigger_extremes();
    test_timeouts();
    test_early_edges();
    test_start_while_busy();
    test_register_decode();
    test_long_echo();
    test_random_traffic();
    // Drain and let the core go quiet
    settle_measurement();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- ultrasonic_ranging_with_smoothing_core.f -----
+incdir+rtl
rtl/urs_pkg.sv
rtl/ultrasonic_ranging_with_smoothing_core.sv
verif/tb_ultrasonic_ranging_with_smoothing_core.sv
